@@ sv/lhe_pkg.sv @@
// Shared types and constants for the latency histogram engine.
// No dependencies; the files that use this package refer to it by scoped names.
package lhe_pkg;

  localparam int FINE_BINS_DEF    = 2048;
  localparam int COARSE_BINS_DEF  = 128;
  localparam int FINE_RES_US_DEF  = 10;
  localparam int COARSE_RATIO_DEF = 10000;
  localparam int NUM_CLASSES_DEF  = 3;

  localparam int USEC_PER_SEC = 1000000;
  localparam int CNT_W        = 64;
  localparam int BIN_W        = 12;
  localparam int CLS_W        = 2;
  // tier-local index width at the largest fine tier the parameters allow
  localparam int IDX_W        = 18;
  localparam int Q_DEPTH      = 2;

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef struct packed {
    logic             record;
    logic             cls_ok;
    logic [CLS_W-1:0] cls;
    logic             coarse;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [BIN_W-1:0] bin_used;
  } job_t;

  typedef struct packed {
    logic [CNT_W-1:0] bin_count;
    logic [CNT_W-1:0] class_total;
    logic [BIN_W-1:0] bin_used;
    logic             is_coarse;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic load;
  } back_stat_t;

endpackage

@@ sv/lhe_in_if.sv @@
// Input channel of the latency histogram engine: valid/ready plus one item.
// Standalone; no package dependency.
interface lhe_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  op_class;
  logic [31:0] begin_seconds;
  logic [19:0] begin_micros;
  logic [31:0] end_seconds;
  logic [19:0] end_micros;
  logic [11:0] read_bin;

  modport source (output valid, mode, op_class, begin_seconds, begin_micros,
                  end_seconds, end_micros, read_bin, input ready);
  modport sink   (input valid, mode, op_class, begin_seconds, begin_micros,
                  end_seconds, end_micros, read_bin, output ready);
endinterface

@@ sv/lhe_out_if.sv @@
// Result channel of the latency histogram engine: valid/ready plus one result.
// Standalone; no package dependency.
interface lhe_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] bin_count;
  logic [63:0] class_total;
  logic [11:0] bin_used;
  logic        is_coarse;

  modport source (output valid, bin_count, class_total, bin_used, is_coarse,
                  input ready);
  modport sink   (input valid, bin_count, class_total, bin_used, is_coarse,
                  output ready);
endinterface

@@ sv/lhe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lhe_ram #(
  parameter int  WIDTH = 64,
  parameter int  DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/lhe_front.sv @@
// Front end: accepts items, forms elapsed time and maps it to a bin.
// Uses lhe_pkg and lhe_in_if; hands jobs to the queue.
module lhe_front #(
  parameter int FINE_BINS    = lhe_pkg::FINE_BINS_DEF,
  parameter int COARSE_BINS  = lhe_pkg::COARSE_BINS_DEF,
  parameter int FINE_RES_US  = lhe_pkg::FINE_RES_US_DEF,
  parameter int COARSE_RATIO = lhe_pkg::COARSE_RATIO_DEF,
  parameter int NUM_CLASSES  = lhe_pkg::NUM_CLASSES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept_en,
  lhe_in_if.sink        in_bus,
  output lhe_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_ready
);

  localparam int EW  = 54;
  localparam int QW  = ($clog2(FINE_BINS) > $clog2(COARSE_BINS)) ?
                       $clog2(FINE_BINS) : $clog2(COARSE_BINS);

  localparam longint FX  = longint'(FINE_BINS) * longint'(FINE_RES_US);
  localparam longint CDV = longint'(FINE_RES_US) * longint'(COARSE_RATIO);
  localparam longint CX  = longint'(COARSE_BINS) * CDV;
  localparam int     KF  = $clog2(FX * longint'(FINE_RES_US));
  localparam int     KC  = $clog2(CX * CDV);
  localparam longint MF  = ((longint'(1) << KF) + longint'(FINE_RES_US) - 1) /
                           longint'(FINE_RES_US);
  localparam longint MC  = ((longint'(1) << KC) + CDV - 1) / CDV;
  localparam int     XFW = $clog2(FX);
  localparam int     XCW = $clog2(CX);
  localparam int     XW  = (XFW > XCW) ? XFW : XCW;
  localparam int     PFW = XFW + $clog2(MF + 1);
  localparam int     PCW = XCW + $clog2(MC + 1);

  localparam logic [EW-1:0] USEC     = EW'(lhe_pkg::USEC_PER_SEC);
  localparam logic [EW-1:0] FINE_LIM = EW'(FX);
  localparam logic [EW-1:0] SAT_LIM  = EW'(FX + CX);
  localparam logic [QW-1:0] C_LAST   = QW'(COARSE_BINS - 1);

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_MUL   = 6'b000010,
    F_ADD   = 6'b000100,
    F_SETUP = 6'b001000,
    F_DIV   = 6'b010000,
    F_PUSH  = 6'b100000
  } fstate_t;

  fstate_t              state_r, state_nxt;
  lhe_pkg::job_t        job_r, job_nxt;
  logic signed [32:0]   ds_r, ds_nxt;
  logic signed [20:0]   du_r, du_nxt;
  logic [EW-1:0]        el_r, el_nxt;
  logic [XW-1:0]        rem_r, rem_nxt;
  logic [QW-1:0]        q_r, q_nxt;

  logic [EW-1:0]        sum;
  logic [PFW-1:0]       fprod;
  logic [PCW-1:0]       cprod;
  logic [31:0]          rb_off;
  logic                 rb_coarse;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    ds_r  <= ds_nxt;
    du_r  <= du_nxt;
    el_r  <= el_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign in_bus.ready = (state_r == F_IDLE) && accept_en;
  assign sum          = el_r + {{(EW-21){du_r[20]}}, du_r};
  assign fprod        = PFW'(rem_r[XFW-1:0]) * PFW'(MF);
  assign cprod        = PCW'(rem_r[XCW-1:0]) * PCW'(MC);
  assign rb_off       = 32'(in_bus.read_bin) - 32'(FINE_BINS);
  assign rb_coarse    = 32'(in_bus.read_bin) >= 32'(FINE_BINS);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    ds_nxt    = ds_r;
    du_nxt    = du_r;
    el_nxt    = el_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_bus.valid && in_bus.ready) begin
          ds_nxt         = $signed({1'b0, in_bus.end_seconds}) -
                           $signed({1'b0, in_bus.begin_seconds});
          du_nxt         = $signed({1'b0, in_bus.end_micros}) -
                           $signed({1'b0, in_bus.begin_micros});
          job_nxt.record = (in_bus.mode == lhe_pkg::MODE_RECORD);
          job_nxt.cls    = in_bus.op_class;
          job_nxt.cls_ok = 32'(in_bus.op_class) < 32'(NUM_CLASSES);
          if (in_bus.mode == lhe_pkg::MODE_RECORD) begin
            job_nxt.hit = 1'b1;
            state_nxt   = F_MUL;
          end else begin
            job_nxt.coarse   = rb_coarse;
            job_nxt.hit      = !rb_coarse || (rb_off < 32'(COARSE_BINS));
            job_nxt.idx      = rb_coarse ? lhe_pkg::IDX_W'(rb_off) :
                                           lhe_pkg::IDX_W'(in_bus.read_bin);
            job_nxt.bin_used = in_bus.read_bin;
            state_nxt        = F_PUSH;
          end
        end
      end
      F_MUL: begin
        el_nxt    = $signed({{(EW-33){ds_r[32]}}, ds_r}) * $signed(USEC);
        state_nxt = F_ADD;
      end
      F_ADD: begin
        el_nxt    = sum[EW-1] ? '0 : sum;
        state_nxt = F_SETUP;
      end
      F_SETUP: begin
        q_nxt = '0;
        if (el_r < FINE_LIM) begin
          job_nxt.coarse = 1'b0;
          rem_nxt        = XW'(el_r);
          state_nxt      = F_DIV;
        end else if (el_r >= SAT_LIM) begin
          job_nxt.coarse = 1'b1;
          q_nxt          = C_LAST;
          state_nxt      = F_PUSH;
        end else begin
          job_nxt.coarse = 1'b1;
          rem_nxt        = XW'(el_r - FINE_LIM);
          state_nxt      = F_DIV;
        end
      end
      F_DIV: begin
        q_nxt     = job_r.coarse ? QW'(cprod >> KC) : QW'(fprod >> KF);
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (job_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    job = job_r;
    if (job_r.record) begin
      job.idx      = lhe_pkg::IDX_W'(q_r);
      job.bin_used = job_r.coarse ? lhe_pkg::BIN_W'(32'(q_r) + 32'(FINE_BINS)) :
                                    lhe_pkg::BIN_W'(q_r);
    end
  end

  assign job_valid = (state_r == F_PUSH);

endmodule

@@ sv/lhe_queue.sv @@
// Short job queue between the front end and the back end.
// Uses lhe_pkg for the job type and depth.
module lhe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  lhe_pkg::job_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output lhe_pkg::job_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);

  localparam int PW = $clog2(lhe_pkg::Q_DEPTH);
  localparam int CW = $clog2(lhe_pkg::Q_DEPTH + 1);

  lhe_pkg::job_t mem_r [lhe_pkg::Q_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;
  logic          push, pop;

  assign push_ready = cnt_r != CW'(lhe_pkg::Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (32'(wptr_r) == lhe_pkg::Q_DEPTH - 1) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (32'(rptr_r) == lhe_pkg::Q_DEPTH - 1) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ sv/lhe_back.sv @@
// Back end: clears the counter memories, then does read-modify-write per job.
// Uses lhe_pkg, lhe_out_if and lhe_ram; owns the result register.
module lhe_back #(
  parameter int FINE_BINS   = lhe_pkg::FINE_BINS_DEF,
  parameter int COARSE_BINS = lhe_pkg::COARSE_BINS_DEF,
  parameter int NUM_CLASSES = lhe_pkg::NUM_CLASSES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lhe_pkg::job_t       job,
  input  logic                job_valid,
  output logic                job_ready,
  lhe_out_if.source           out_bus,
  output lhe_pkg::back_stat_t stat
);

  localparam int FD  = NUM_CLASSES * FINE_BINS;
  localparam int CD  = NUM_CLASSES * COARSE_BINS;
  localparam int FAW = (FD > 1) ? $clog2(FD) : 1;
  localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
  localparam int MD  = (FD > CD) ? FD : CD;
  localparam int MAW = (FAW > CAW) ? FAW : CAW;
  localparam int CW  = lhe_pkg::CNT_W;

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_UPD   = 3'b100
  } bstate_t;

  bstate_t              state_r;
  logic [MAW-1:0]       clr_cnt_r;
  lhe_pkg::job_t        job_r;
  logic [FAW-1:0]       faddr_r;
  logic [CAW-1:0]       caddr_r;
  logic [CW-1:0]        tot_r [NUM_CLASSES];
  lhe_pkg::result_t     out_r;
  logic                 out_valid_r;

  logic                 pop, out_free, upd, bump;
  logic [FAW-1:0]       f_raddr, f_waddr;
  logic [CAW-1:0]       c_raddr, c_waddr;
  logic                 f_we, c_we;
  logic [CW-1:0]        wdata, f_rdata, c_rdata, rd, count, tot_sel, tot_new;

  assign out_free  = !out_valid_r || out_bus.ready;
  assign job_ready = (state_r == B_IDLE) && out_free;
  assign pop       = job_valid && job_ready;
  assign upd       = (state_r == B_UPD);
  assign bump      = upd && job_r.record && job_r.cls_ok;

  assign f_raddr = FAW'(32'(job.cls) * 32'(FINE_BINS) + 32'(job.idx));
  assign c_raddr = CAW'(32'(job.cls) * 32'(COARSE_BINS) + 32'(job.idx));

  assign rd      = job_r.coarse ? c_rdata : f_rdata;
  assign count   = job_r.record ? rd + CW'(1) : rd;
  assign tot_new = job_r.record ? tot_sel + CW'(1) : tot_sel;

  always_comb begin
    tot_sel = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (32'(job_r.cls) == i) begin
        tot_sel = tot_r[i];
      end
    end
  end

  always_comb begin
    if (state_r == B_CLEAR) begin
      f_we    = 32'(clr_cnt_r) < FD;
      c_we    = 32'(clr_cnt_r) < CD;
      f_waddr = clr_cnt_r[FAW-1:0];
      c_waddr = clr_cnt_r[CAW-1:0];
      wdata   = '0;
    end else begin
      f_we    = bump && !job_r.coarse;
      c_we    = bump && job_r.coarse;
      f_waddr = faddr_r;
      c_waddr = caddr_r;
      wdata   = count;
    end
  end

  lhe_ram #(.WIDTH(CW), .DEPTH(FD)) u_fine_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  lhe_ram #(.WIDTH(CW), .DEPTH(CD)) u_coarse_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        tot_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        B_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (32'(clr_cnt_r) == MD - 1) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop) begin
            state_r <= B_UPD;
          end
        end
        B_UPD: begin
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
      if (upd) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (bump) begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
          if (32'(job_r.cls) == i) begin
            tot_r[i] <= tot_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r   <= job;
      faddr_r <= f_raddr;
      caddr_r <= c_raddr;
    end
    if (upd) begin
      out_r.bin_count   <= (job_r.cls_ok && job_r.hit) ? count : '0;
      out_r.class_total <= job_r.cls_ok ? tot_new : '0;
      out_r.bin_used    <= job_r.bin_used;
      out_r.is_coarse   <= job_r.coarse;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.bin_count   = out_r.bin_count;
  assign out_bus.class_total = out_r.class_total;
  assign out_bus.bin_used    = out_r.bin_used;
  assign out_bus.is_coarse   = out_r.is_coarse;

  assign stat.clearing = (state_r == B_CLEAR);
  assign stat.load     = upd;

endmodule

@@ sv/latency_histogram_engine.sv @@
// Latency histogram engine: three-tier top level joining front, queue and back.
// Uses lhe_pkg, lhe_in_if, lhe_out_if, lhe_front, lhe_queue and lhe_back.
//
// Usage:
//   in_bus carries one item per beat: a record (mode 0) with begin/end
//   timestamps, or a read (mode 1) of one bin selected by read_bin. out_bus
//   returns exactly one result beat per item, in order: bin count, class
//   total, combined bin index and tier flag.
//   The front end takes a record through a constant multiply, an add, a
//   range check and a reciprocal multiply that yields the bin, each in its
//   own state; a saturating record skips the reciprocal multiply, and a read
//   goes straight to the push state. The back end does a memory read-modify-write
//   per item in fewer states, so the front end sets the record rate. With the
//   queue and back end idle, an item passes the front states, the queue and the
//   back end update state before result valid rises.
//   After reset the back end sweeps both counter memories to zero, one
//   address a cycle, over max(NUM_CLASSES*FINE_BINS, NUM_CLASSES*COARSE_BINS)
//   addresses (6144 at the defaults); in_bus.ready stays low until it is done.
//   A stalled receiver holds the result register; the queue then fills and
//   the front end stops accepting new beats.
module latency_histogram_engine #(
  parameter int FINE_BINS    = lhe_pkg::FINE_BINS_DEF,
  parameter int COARSE_BINS  = lhe_pkg::COARSE_BINS_DEF,
  parameter int FINE_RES_US  = lhe_pkg::FINE_RES_US_DEF,
  parameter int COARSE_RATIO = lhe_pkg::COARSE_RATIO_DEF,
  parameter int NUM_CLASSES  = lhe_pkg::NUM_CLASSES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  lhe_in_if.sink    in_bus,
  lhe_out_if.source out_bus
);

  lhe_pkg::job_t       fq_job, qb_job;
  logic                fq_valid, fq_ready, qb_valid, qb_ready;
  lhe_pkg::back_stat_t stat;

  lhe_front #(
    .FINE_BINS    (FINE_BINS),
    .COARSE_BINS  (COARSE_BINS),
    .FINE_RES_US  (FINE_RES_US),
    .COARSE_RATIO (COARSE_RATIO),
    .NUM_CLASSES  (NUM_CLASSES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_en (!stat.clearing),
    .in_bus    (in_bus),
    .job       (fq_job),
    .job_valid (fq_valid),
    .job_ready (fq_ready)
  );

  lhe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (fq_job),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .pop_data   (qb_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready)
  );

  lhe_back #(
    .FINE_BINS   (FINE_BINS),
    .COARSE_BINS (COARSE_BINS),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (qb_job),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .out_bus   (out_bus),
    .stat      (stat)
  );

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_bus.ready)
    else $error("input beat possible during clearing sweep");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !out_bus.valid)
    else $error("result beat during clearing sweep");

  a_load_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.load |-> !out_bus.valid)
    else $error("result register overwritten while holding a beat");
`endif

endmodule

@@ dv/latency_histogram_engine_tb.sv @@
// Self-checking testbench for latency_histogram_engine: directed table, then random beats.
// Results are checked against an in-bench histogram predictor or a typed table entry.
// Depends on lhe_pkg, lhe_in_if, lhe_out_if and the engine RTL.
module latency_histogram_engine_tb;

  localparam int FINE_N     = lhe_pkg::FINE_BINS_DEF;
  localparam int COARSE_N   = lhe_pkg::COARSE_BINS_DEF;
  localparam int RES_US     = lhe_pkg::FINE_RES_US_DEF;
  localparam int RATIO      = lhe_pkg::COARSE_RATIO_DEF;
  localparam int CLASS_N    = lhe_pkg::NUM_CLASSES_DEF;
  localparam int RANDOM_N   = 500;
  localparam int QUIET_MAX  = 30000;
  localparam int TAIL_WAIT  = 40;

  typedef struct packed {
    logic        mode;
    logic [1:0]  op_class;
    logic [31:0] begin_seconds;
    logic [19:0] begin_micros;
    logic [31:0] end_seconds;
    logic [19:0] end_micros;
    logic [11:0] read_bin;
  } sample_t;

  typedef struct {
    sample_t          s;
    bit               typed;
    lhe_pkg::result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic rx_ready = 1'b0;

  lhe_in_if  in_bus ();
  lhe_out_if out_bus ();

  assign out_bus.ready = rx_ready;

  latency_histogram_engine dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #6 clk = ~clk;

  bit [63:0] fine_cnt   [CLASS_N][FINE_N];
  bit [63:0] coarse_cnt [CLASS_N][COARSE_N];
  bit [63:0] class_tot  [CLASS_N];

  lhe_pkg::result_t pending_results [$];
  logic [11:0]      hot_bins [$];
  dir_row_t         dir_rows [$];
  int               errors = 0;
  int               burst_left;

  function automatic lhe_pkg::result_t histogram_update(input sample_t s);
    lhe_pkg::result_t r;
    longint           bsec, esec, bus, eus, elapsed;
    longint unsigned  fine_idx, crs_idx;
    bit               cls_ok;
    r = '0;
    cls_ok = s.op_class < CLASS_N;
    if (s.mode == lhe_pkg::MODE_RECORD) begin
      bsec = s.begin_seconds;
      esec = s.end_seconds;
      bus = s.begin_micros;
      eus = s.end_micros;
      elapsed = (esec - bsec) * lhe_pkg::USEC_PER_SEC + (eus - bus);
      if (elapsed < 0) elapsed = 0;
      fine_idx = elapsed / RES_US;
      if (fine_idx < FINE_N) begin
        r.bin_used = fine_idx[11:0];
        r.is_coarse = 1'b0;
        if (cls_ok) begin
          fine_cnt[s.op_class][fine_idx] += 64'd1;
          r.bin_count = fine_cnt[s.op_class][fine_idx];
        end
      end else begin
        crs_idx = (fine_idx - FINE_N) / RATIO;
        if (crs_idx >= COARSE_N) crs_idx = COARSE_N - 1;
        r.bin_used = 12'(FINE_N + crs_idx);
        r.is_coarse = 1'b1;
        if (cls_ok) begin
          coarse_cnt[s.op_class][crs_idx] += 64'd1;
          r.bin_count = coarse_cnt[s.op_class][crs_idx];
        end
      end
      if (cls_ok) begin
        class_tot[s.op_class] += 64'd1;
        r.class_total = class_tot[s.op_class];
      end
    end else begin
      r.bin_used = s.read_bin;
      r.is_coarse = s.read_bin >= FINE_N;
      if (cls_ok) begin
        r.class_total = class_tot[s.op_class];
        if (s.read_bin < FINE_N)
          r.bin_count = fine_cnt[s.op_class][s.read_bin];
        else if (s.read_bin < FINE_N + COARSE_N)
          r.bin_count = coarse_cnt[s.op_class][s.read_bin - FINE_N];
      end
    end
    return r;
  endfunction

  function automatic sample_t rec_item(input logic [1:0] cls, input logic [31:0] bsec,
                                       input logic [19:0] bus, input logic [31:0] esec,
                                       input logic [19:0] eus);
    sample_t s;
    s = '{lhe_pkg::MODE_RECORD, cls, bsec, bus, esec, eus, 12'hFFF};
    return s;
  endfunction

  function automatic sample_t read_item(input logic [1:0] cls, input logic [11:0] bin);
    sample_t s;
    s = '{lhe_pkg::MODE_READ, cls, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF, 20'hFFFFF, bin};
    return s;
  endfunction

  function automatic void note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  task automatic issue(input sample_t s, input bit typed, input lhe_pkg::result_t want);
    lhe_pkg::result_t predicted;
    in_bus.valid         <= 1'b1;
    in_bus.mode          <= s.mode;
    in_bus.op_class      <= s.op_class;
    in_bus.begin_seconds <= s.begin_seconds;
    in_bus.begin_micros  <= s.begin_micros;
    in_bus.end_seconds   <= s.end_seconds;
    in_bus.end_micros    <= s.end_micros;
    in_bus.read_bin      <= s.read_bin;
    do @(posedge clk); while (!in_bus.ready);
    predicted = histogram_update(s);
    pending_results.push_back(typed ? want : predicted);
    if (s.mode == lhe_pkg::MODE_RECORD && s.op_class < CLASS_N) begin
      hot_bins.push_back(predicted.bin_used);
      if (hot_bins.size() > 24) void'(hot_bins.pop_front());
    end
    burst_left--;
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // hold off until every expected beat is back
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin : stimulus
    sample_t         s;
    int              kind;
    longint unsigned elapsed, span;
    rst_n                = 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.mode          <= lhe_pkg::MODE_RECORD;
    in_bus.op_class      <= '0;
    in_bus.begin_seconds <= '0;
    in_bus.begin_micros  <= '0;
    in_bus.end_seconds   <= '0;
    in_bus.end_micros    <= '0;
    in_bus.read_bin      <= '0;

    dir_rows.push_back('{read_item(2'd0, 12'd0), 1'b1, '{64'd0, 64'd0, 12'd0, 1'b0}});
    dir_rows.push_back('{read_item(2'd2, 12'd4095), 1'b1, '{64'd0, 64'd0, 12'd4095, 1'b1}});
    dir_rows.push_back('{rec_item(2'd0, 32'd0, 20'd0, 32'd0, 20'd0), 1'b1,
                         '{64'd1, 64'd1, 12'd0, 1'b0}});
    dir_rows.push_back('{rec_item(2'd1, 32'd5, 20'd999999, 32'd5, 20'd0), 1'b1,
                         '{64'd1, 64'd1, 12'd0, 1'b0}});
    dir_rows.push_back('{rec_item(2'd3, 32'd7, 20'd0, 32'd7, 20'd0), 1'b1,
                         '{64'd0, 64'd0, 12'd0, 1'b0}});
    dir_rows.push_back('{read_item(2'd3, 12'd2048), 1'b1, '{64'd0, 64'd0, 12'd2048, 1'b1}});
    dir_rows.push_back('{rec_item(2'd2, 32'd0, 20'd0, 32'hFFFF_FFFF, 20'd999999), 1'b1,
                         '{64'd1, 64'd1, 12'd2175, 1'b1}});
    dir_rows.push_back('{rec_item(2'd0, 32'd0, 20'd0, 32'd0, 20'd20479), 1'b0, '0});
    dir_rows.push_back('{rec_item(2'd0, 32'd100, 20'd500000, 32'd100, 20'd520480), 1'b0, '0});
    dir_rows.push_back('{rec_item(2'd0, 32'd0, 20'd0, 32'd12, 20'd720479), 1'b0, '0});
    dir_rows.push_back('{rec_item(2'd0, 32'd0, 20'd0, 32'd12, 20'd720480), 1'b0, '0});
    dir_rows.push_back('{rec_item(2'd1, 32'd0, 20'd0, 32'd0, 20'hFFFFF), 1'b0, '0});
    dir_rows.push_back('{rec_item(2'd1, 32'd1, 20'hFFFFF, 32'd2, 20'd0), 1'b0, '0});
    dir_rows.push_back('{rec_item(2'd2, 32'hFFFF_FFFF, 20'hFFFFF, 32'd0, 20'd0), 1'b0, '0});
    dir_rows.push_back('{rec_item(2'd0, 32'd3, 20'd0, 32'd3, 20'd20479), 1'b0, '0});
    dir_rows.push_back('{read_item(2'd0, 12'd2047), 1'b0, '0});
    dir_rows.push_back('{read_item(2'd0, 12'd2048), 1'b0, '0});
    dir_rows.push_back('{read_item(2'd0, 12'd2175), 1'b0, '0});
    dir_rows.push_back('{read_item(2'd1, 12'd2176), 1'b0, '0});
    dir_rows.push_back('{read_item(2'd2, 12'd0), 1'b0, '0});
    dir_rows.push_back('{read_item(2'd1, 12'd0), 1'b0, '0});
    dir_rows.push_back('{read_item(2'd3, 12'd4095), 1'b1, '{64'd0, 64'd0, 12'd4095, 1'b1}});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = $urandom_range(1, 40);

    foreach (dir_rows[i]) issue(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].want);
    drain();

    for (int n = 0; n < RANDOM_N; n++) begin
      kind = $urandom_range(0, 99);
      s.mode          = lhe_pkg::MODE_READ;
      s.op_class      = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      s.begin_seconds = $urandom();
      s.begin_micros  = 20'($urandom_range(0, 20'hFFFFF));
      s.end_seconds   = $urandom();
      s.end_micros    = 20'($urandom_range(0, 20'hFFFFF));
      s.read_bin      = 12'($urandom());
      if (kind < 50) begin
        s.mode = lhe_pkg::MODE_RECORD;
        if (kind < 30)
          elapsed = $urandom_range(0, 1) ? $urandom_range(0, 159) : $urandom_range(0, 20479);
        else
          elapsed = 20480 + $urandom_range(0, 13000000);
        s.begin_seconds = $urandom_range(0, 32'h7FFF_FFFF);
        s.begin_micros  = 20'($urandom_range(0, 999999));
        span = s.begin_micros + elapsed;
        s.end_seconds   = 32'(s.begin_seconds + span / lhe_pkg::USEC_PER_SEC);
        s.end_micros    = 20'(span % lhe_pkg::USEC_PER_SEC);
      end else if (kind < 60) begin
        s.mode = 1'($urandom_range(0, 1));
      end else if (kind < 90) begin
        if (hot_bins.size() != 0)
          s.read_bin = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
        else
          s.read_bin = 12'($urandom_range(0, FINE_N + COARSE_N - 1));
      end
      issue(s, 1'b0, '0);
      if (n == RANDOM_N / 2) drain();
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin : result_check
    lhe_pkg::result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected beat: count %0d total %0d bin %0d coarse %0b",
                               out_bus.bin_count, out_bus.class_total, out_bus.bin_used,
                               out_bus.is_coarse));
      end else begin
        want = pending_results.pop_front();
        if (out_bus.bin_count !== want.bin_count || out_bus.class_total !== want.class_total ||
            out_bus.bin_used !== want.bin_used || out_bus.is_coarse !== want.is_coarse)
          note_failure($sformatf(
            "mismatch: exp count %0d total %0d bin %0d coarse %0b, got %0d %0d %0d %0b",
            want.bin_count, want.class_total, want.bin_used, want.is_coarse,
            out_bus.bin_count, out_bus.class_total, out_bus.bin_used, out_bus.is_coarse));
      end
    end
  end

  int       stall_left = 0;
  bit [1:0] stall_style = 2'd0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= 2'($urandom_range(0, 2));
      stall_left  <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      2'd0: begin
        rx_ready <= 1'b1;
      end
      2'd1: begin
        rx_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        rx_ready <= (stall_left % 12) == 0;
      end
    endcase
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ latency_histogram_engine.f @@
sv/lhe_pkg.sv
sv/lhe_in_if.sv
sv/lhe_out_if.sv
sv/lhe_ram.sv
sv/lhe_front.sv
sv/lhe_queue.sv
sv/lhe_back.sv
sv/latency_histogram_engine.sv
dv/latency_histogram_engine_tb.sv
